>>> hw/rtl/motor_soft_start_direction_fsm_core_macros.svh
// Assertion helpers shared by the RTL that checks itself.
// Each macro samples on the rising edge of clk and is switched off during reset.
`ifndef MOTOR_SOFT_START_DIRECTION_FSM_CORE_MACROS_SVH
`define MOTOR_SOFT_START_DIRECTION_FSM_CORE_MACROS_SVH

// Same-cycle implication.
`define MSSDF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define MSSDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/mssdf_pkg.sv
package mssdf_pkg;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_FWD    = 3'd1,
        CMD_BWD    = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_DIRECT = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        RUN_STOP = 2'd0,
        RUN_FWD  = 2'd1,
        RUN_BWD  = 2'd2
    } run_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_CALC,
        CTL_FINISH
    } ctl_state_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_MUL,
        RS_DIV,
        RS_DONE
    } ramp_state_t;

    typedef enum logic [1:0] {
        CFG_SPEED_LIMIT = 2'd0,
        CFG_RAMP_TIME   = 2'd1,
        CFG_TICK_INTVL  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic start;
    } ramp_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ramp_sts_t;

    localparam int MIN_SPEED_INT = 30;

    localparam logic [6:0]  SPEED_LIMIT_RST = 7'd117;
    localparam logic [15:0] RAMP_TIME_RST   = 16'd2000;
    localparam logic [15:0] TICK_INTVL_RST  = 16'd200;

    localparam logic signed [15:0] DIRECT_MAX = 16'sd127;
    localparam logic signed [15:0] DIRECT_MIN = -16'sd127;
    localparam logic signed [7:0]  DRIVE_MAX  = 8'sd127;
    localparam logic signed [7:0]  DRIVE_MIN  = -8'sd127;

endpackage

>>> hw/rtl/mssdf_req_if.sv
interface mssdf_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic               inhibit;
    logic signed [15:0] direct_speed;

    modport source (output valid, output cmd, output inhibit, output direct_speed,
                    input ready);
    modport sink   (input valid, input cmd, input inhibit, input direct_speed,
                    output ready);
endinterface

>>> hw/rtl/mssdf_res_if.sv
interface mssdf_res_if;
    logic              valid;
    logic              ready;
    logic              drive_write;
    logic signed [7:0] drive;
    logic [1:0]        run_state;
    logic              rejected;

    modport source (output valid, output drive_write, output drive, output run_state,
                    output rejected, input ready);
    modport sink   (input valid, input drive_write, input drive, input run_state,
                    input rejected, output ready);
endinterface

>>> hw/rtl/motor_soft_start_direction_fsm_core.sv
// Soft-start motor controller with stop / forward / backward run states.
// request (sink): cmd, inhibit, direct_speed; taken when valid and ready are high.
// result (source): drive_write, drive, run_state, rejected; one per request.
// cfg_write / cfg_index / cfg_data: 0 speed limit, 1 ramp time, 2 tick interval;
// write only while no request is outstanding.
// A tick while running passes through the serial ramp unit: 16 multiply steps
// (one tick-interval bit each), 23 + FRAC_BITS divide steps (one quotient bit
// each), one saturate step and one hand-over step; the next request is taken
// only once its result has moved into the output register. Every other request,
// and a tick while stopped or inhibited, skips the ramp unit and goes straight
// to the hand-over step.
// The result sits in an output register: while a stalled receiver holds it,
// the next request is still taken and waits finished; the request after that
// waits until the receiver takes the held result.
// Reset stops the motor, clears the ramp speed and loads the register defaults
// (limit 117, ramp time 2000, tick interval 200); no result is pending.
module motor_soft_start_direction_fsm_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    mssdf_req_if.sink   request,
    mssdf_res_if.source result,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    `include "motor_soft_start_direction_fsm_core_macros.svh"

    localparam int W = 7 + FRAC_BITS;
    localparam logic [W-1:0] SMIN = W'(mssdf_pkg::MIN_SPEED_INT) << FRAC_BITS;

    // configuration
    logic [6:0]  speed_limit_reg;
    logic [15:0] ramp_time_reg;
    logic [15:0] tick_intvl_reg;

    // control state
    mssdf_pkg::ctl_state_t state_reg, state_next;
    mssdf_pkg::run_t       motion_reg, motion_next;
    logic [W-1:0]          speed_reg;
    logic                  res_valid_reg, res_valid_next;

    // result waiting for the output register
    logic              pend_write_reg;
    logic signed [7:0] pend_drive_reg;
    logic              pend_rej_reg;
    mssdf_pkg::run_t   pend_run_reg;

    // output register
    logic              out_write_reg;
    logic signed [7:0] out_drive_reg;
    logic              out_rej_reg;
    mssdf_pkg::run_t   out_run_reg;

    mssdf_pkg::cmd_t      cmd;
    mssdf_pkg::ramp_ctl_t ramp_ctl;
    mssdf_pkg::ramp_sts_t ramp_sts;
    logic [W-1:0]         ramp_speed;

    logic              accept;
    logic              tick_run;
    logic              out_free;
    logic              load_out;
    logic              dec_write;
    logic signed [7:0] dec_drive;
    logic              dec_rej;
    logic              dec_clear;
    logic signed [7:0] run_mag;
    logic signed [7:0] run_drive;

    assign cmd      = mssdf_pkg::cmd_t'(request.cmd);
    assign tick_run = (cmd == mssdf_pkg::CMD_TICK) && (motion_reg != mssdf_pkg::RUN_STOP)
                      && !request.inhibit;
    assign out_free = !res_valid_reg || result.ready;

    // drive from the fresh ramp speed: integer part, negated when running backward
    assign run_mag   = signed'({1'b0, ramp_speed[W-1:FRAC_BITS]});
    assign run_drive = (motion_reg == mssdf_pkg::RUN_BWD) ? -run_mag : run_mag;

    mssdf_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ramp_ctl),
        .speed     (speed_reg),
        .limit     (speed_limit_reg),
        .ramp_time (ramp_time_reg),
        .interval  (tick_intvl_reg),
        .sts       (ramp_sts),
        .new_speed (ramp_speed)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mssdf_pkg::CTL_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = tick_run ? mssdf_pkg::CTL_CALC : mssdf_pkg::CTL_FINISH;
                end
            end
            mssdf_pkg::CTL_CALC:
            begin
                if (ramp_sts.done)
                begin
                    state_next = mssdf_pkg::CTL_FINISH;
                end
            end
            mssdf_pkg::CTL_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mssdf_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = mssdf_pkg::CTL_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        request.ready  = (state_reg == mssdf_pkg::CTL_IDLE);
        accept         = (state_reg == mssdf_pkg::CTL_IDLE) && request.valid;
        ramp_ctl.start = accept && tick_run;
        load_out       = (state_reg == mssdf_pkg::CTL_FINISH) && out_free;
    end

    // Decode the request: direction changes take effect at acceptance
    always_comb
    begin
        motion_next = motion_reg;
        dec_write   = 1'b0;
        dec_drive   = '0;
        dec_rej     = 1'b0;
        dec_clear   = 1'b0;
        case (cmd)
            mssdf_pkg::CMD_TICK:
            begin
                dec_write = 1'b1;
                // stopped or inhibited: drop the speed and write a zero drive
                dec_clear = !tick_run;
            end
            mssdf_pkg::CMD_FWD:
            begin
                if (motion_reg == mssdf_pkg::RUN_BWD)
                begin
                    dec_rej = 1'b1;
                end
                else
                begin
                    motion_next = mssdf_pkg::RUN_FWD;
                end
            end
            mssdf_pkg::CMD_BWD:
            begin
                if (motion_reg == mssdf_pkg::RUN_FWD)
                begin
                    dec_rej = 1'b1;
                end
                else
                begin
                    motion_next = mssdf_pkg::RUN_BWD;
                end
            end
            mssdf_pkg::CMD_STOP:
            begin
                motion_next = mssdf_pkg::RUN_STOP;
            end
            mssdf_pkg::CMD_DIRECT:
            begin
                dec_write = 1'b1;
                if (request.direct_speed > mssdf_pkg::DIRECT_MAX)
                begin
                    dec_drive = mssdf_pkg::DRIVE_MAX;
                end
                else if (request.direct_speed < mssdf_pkg::DIRECT_MIN)
                begin
                    dec_drive = mssdf_pkg::DRIVE_MIN;
                end
                else
                begin
                    dec_drive = request.direct_speed[7:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold the output valid until taken; reload it as the pending result moves in
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mssdf_pkg::CTL_IDLE;
            motion_reg      <= mssdf_pkg::RUN_STOP;
            speed_reg       <= '0;
            res_valid_reg   <= 1'b0;
            speed_limit_reg <= mssdf_pkg::SPEED_LIMIT_RST;
            ramp_time_reg   <= mssdf_pkg::RAMP_TIME_RST;
            tick_intvl_reg  <= mssdf_pkg::TICK_INTVL_RST;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                motion_reg <= motion_next;
                if (dec_clear)
                begin
                    speed_reg <= '0;
                end
            end
            if ((state_reg == mssdf_pkg::CTL_CALC) && ramp_sts.done)
            begin
                speed_reg <= ramp_speed;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    mssdf_pkg::CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data[6:0];
                    mssdf_pkg::CFG_RAMP_TIME:   ramp_time_reg   <= cfg_data;
                    mssdf_pkg::CFG_TICK_INTVL:  tick_intvl_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload: pending result and output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_write_reg <= dec_write;
            pend_drive_reg <= dec_drive;
            pend_rej_reg   <= dec_rej;
            pend_run_reg   <= motion_next;
        end
        if ((state_reg == mssdf_pkg::CTL_CALC) && ramp_sts.done)
        begin
            pend_drive_reg <= run_drive;
        end
        if (load_out)
        begin
            out_write_reg <= pend_write_reg;
            out_drive_reg <= pend_drive_reg;
            out_rej_reg   <= pend_rej_reg;
            out_run_reg   <= pend_run_reg;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.drive_write = out_write_reg;
    assign result.drive       = out_drive_reg;
    assign result.run_state   = out_run_reg;
    assign result.rejected    = out_rej_reg;

    // The ramp unit is only ever busy behind an accepted tick
    `MSSDF_ASSERT_NOW(a_ramp_idle_when_ready, request.ready, !ramp_sts.busy)
    // Every accepted request leaves the idle state
    `MSSDF_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != mssdf_pkg::CTL_IDLE)
    // A result without a drive write carries a zero drive
    `MSSDF_ASSERT_NOW(a_no_write_zero_drive, res_valid_reg && !out_write_reg, out_drive_reg == 8'sd0)
    // The ramp speed is either cleared or at least the floor
    `MSSDF_ASSERT_NOW(a_speed_floor, 1'b1, speed_reg == '0 || speed_reg >= SMIN)

endmodule

>>> hw/rtl/mssdf_ramp.sv
// Serial ramp step: shift-add multiply, restoring divide, then saturate and floor.
module mssdf_ramp #(
    parameter int FRAC_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mssdf_pkg::ramp_ctl_t   ctl,
    input  logic [6+FRAC_BITS:0]   speed,
    input  logic [6:0]             limit,
    input  logic [15:0]            ramp_time,
    input  logic [15:0]            interval,
    output mssdf_pkg::ramp_sts_t   sts,
    output logic [6+FRAC_BITS:0]   new_speed
);

    localparam int W  = 7 + FRAC_BITS;
    localparam int P  = 16 + W;
    localparam int CW = $clog2(P);
    localparam logic [W-1:0] SMAX = {W{1'b1}};
    localparam logic [W-1:0] SMIN = W'(mssdf_pkg::MIN_SPEED_INT) << FRAC_BITS;

    mssdf_pkg::ramp_state_t state_reg, state_next;

    logic [W-1:0]  dmag_reg;
    logic          neg_reg;
    logic [15:0]   mplier_reg;
    logic [P-1:0]  acc_reg;
    logic [15:0]   rem_reg;
    logic [15:0]   div_reg;
    logic [CW-1:0] cnt_reg;

    logic [W-1:0]  target;
    logic [P-1:0]  addend;
    logic [16:0]   rem_sh;
    logic [16:0]   rem_sub;
    logic          ge;
    logic [P:0]    sum_up;
    logic [W-1:0]  s_up;
    logic [W-1:0]  s_dn;
    logic [W-1:0]  s_sat;

    assign target  = {limit, {FRAC_BITS{1'b0}}};
    assign addend  = mplier_reg[15] ? P'(dmag_reg) : '0;
    assign rem_sh  = {rem_reg, acc_reg[P-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign ge      = rem_sh >= {1'b0, div_reg};

    // acc_reg holds the quotient magnitude once the divide has run
    assign sum_up = {1'b0, acc_reg} + (P+1)'(speed);
    assign s_up   = (sum_up > (P+1)'(SMAX)) ? SMAX : sum_up[W-1:0];
    assign s_dn   = (acc_reg >= P'(speed)) ? '0 : (speed - acc_reg[W-1:0]);
    assign s_sat  = neg_reg ? s_dn : s_up;
    assign new_speed = (s_sat < SMIN) ? SMIN : s_sat;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mssdf_pkg::RS_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = mssdf_pkg::RS_MUL;
                end
            end
            mssdf_pkg::RS_MUL:
            begin
                if (cnt_reg == CW'(15))
                begin
                    state_next = mssdf_pkg::RS_DIV;
                end
            end
            mssdf_pkg::RS_DIV:
            begin
                if (cnt_reg == CW'(P - 1))
                begin
                    state_next = mssdf_pkg::RS_DONE;
                end
            end
            mssdf_pkg::RS_DONE:
            begin
                state_next = mssdf_pkg::RS_IDLE;
            end
            default:
            begin
                state_next = mssdf_pkg::RS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sts.busy = (state_reg != mssdf_pkg::RS_IDLE);
        sts.done = (state_reg == mssdf_pkg::RS_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mssdf_pkg::RS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == mssdf_pkg::RS_MUL || state_reg == mssdf_pkg::RS_DIV)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mssdf_pkg::RS_IDLE:
            begin
                if (ctl.start)
                begin
                    neg_reg    <= speed > target;
                    dmag_reg   <= (speed > target) ? (speed - target) : (target - speed);
                    mplier_reg <= interval;
                    acc_reg    <= '0;
                    rem_reg    <= '0;
                    // a zero time constant counts as one
                    div_reg    <= (ramp_time == '0) ? 16'd1 : ramp_time;
                end
            end
            mssdf_pkg::RS_MUL:
            begin
                acc_reg    <= {acc_reg[P-2:0], 1'b0} + addend;
                mplier_reg <= {mplier_reg[14:0], 1'b0};
            end
            mssdf_pkg::RS_DIV:
            begin
                rem_reg <= ge ? rem_sub[15:0] : rem_sh[15:0];
                acc_reg <= {acc_reg[P-2:0], ge};
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Block parameters and derived widths of the ramp speed.
    localparam int FRAC_BITS = 8;
    localparam int SPEED_W = 7 + FRAC_BITS;
    localparam longint SPEED_TOP = (longint'(1) << SPEED_W) - 1;
    localparam longint SPEED_FLOOR = longint'(mssdf_pkg::MIN_SPEED_INT) << FRAC_BITS;

    // A running tick is the slowest request; allow it plus some slack when settling.
    localparam int TICK_LATENCY = 41 + FRAC_BITS;
    localparam int SETTLE_CYCLES = TICK_LATENCY + 8;
    localparam int CYCLE_LIMIT = 400_000;

    // Command codes outside the decoded set; the block must ignore them.
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;

    // Percentage of cycles in which either side idles, and the long receiver hold-off.
    localparam int IDLE_PCT = 6;
    localparam int HOLD_CYCLES = 300;

    // Marks a directed row whose result is written out in the table.
    localparam bit KNOWN = 1'b1;
    localparam bit PREDICT = 1'b0;

    typedef struct packed {
        logic              drive_write;
        logic signed [7:0] drive;
        mssdf_pkg::run_t   run_state;
        logic              rejected;
    } drive_result_t;

    typedef struct {
        logic [2:0]         cmd;
        logic               inhibit;
        logic signed [15:0] direct_speed;
        bit                 known;
        drive_result_t      want;
    } stimulus_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    mssdf_req_if request_if ();
    mssdf_res_if result_if ();

    motor_soft_start_direction_fsm_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_if),
        .result   (result_if),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the controller: settings, run state and ramp speed.
    logic [6:0]         speed_limit;
    logic [15:0]        ramp_time;
    logic [15:0]        tick_interval;
    mssdf_pkg::run_t    motor_dir;
    logic [SPEED_W-1:0] ramp_speed;

    // Drive results still owed by the block, oldest first.
    drive_result_t pending_results[$];
    drive_result_t oldest;

    int errors;
    int requests_sent;
    int results_seen;
    int ramped_ticks;
    int refusals_seen;
    int settings_applied;
    int cycle_count;
    bit calm;
    bit hold_off_req;
    bit hold_done;

    // Directed requests: extremes of every field, every command and the corner
    // behaviours. Rows marked PREDICT take their result from the shadow model.
    stimulus_row_t directed_rows [24] = '{
        // tick while stopped: drive is written as zero
        '{mssdf_pkg::CMD_TICK, 1'b0, 16'sd0, KNOWN,
          '{1'b1, 8'sd0, mssdf_pkg::RUN_STOP, 1'b0}},
        // direct drive clamps to the limits at both ends of the range
        '{mssdf_pkg::CMD_DIRECT, 1'b0, 16'sh7FFF, KNOWN,
          '{1'b1, 8'sd127, mssdf_pkg::RUN_STOP, 1'b0}},
        '{mssdf_pkg::CMD_DIRECT, 1'b1, 16'sh8000, KNOWN,
          '{1'b1, -8'sd127, mssdf_pkg::RUN_STOP, 1'b0}},
        '{mssdf_pkg::CMD_DIRECT, 1'b0, -16'sd128, KNOWN,
          '{1'b1, -8'sd127, mssdf_pkg::RUN_STOP, 1'b0}},
        '{mssdf_pkg::CMD_DIRECT, 1'b0, 16'sd127, KNOWN,
          '{1'b1, 8'sd127, mssdf_pkg::RUN_STOP, 1'b0}},
        '{mssdf_pkg::CMD_DIRECT, 1'b0, -16'sd127, KNOWN,
          '{1'b1, -8'sd127, mssdf_pkg::RUN_STOP, 1'b0}},
        '{mssdf_pkg::CMD_BWD, 1'b0, 16'sd0, KNOWN,
          '{1'b0, 8'sd0, mssdf_pkg::RUN_BWD, 1'b0}},
        '{mssdf_pkg::CMD_TICK, 1'b0, 16'sd0, PREDICT, '0},
        '{mssdf_pkg::CMD_TICK, 1'b0, 16'sd0, PREDICT, '0},
        // reversing without a stop is refused
        '{mssdf_pkg::CMD_FWD, 1'b0, 16'sd0, KNOWN,
          '{1'b0, 8'sd0, mssdf_pkg::RUN_BWD, 1'b1}},
        // inhibited tick drops the speed and drives zero
        '{mssdf_pkg::CMD_TICK, 1'b1, 16'sd0, KNOWN,
          '{1'b1, 8'sd0, mssdf_pkg::RUN_BWD, 1'b0}},
        '{mssdf_pkg::CMD_TICK, 1'b0, 16'shFFFF, PREDICT, '0},
        // repeated direction is accepted and changes nothing
        '{mssdf_pkg::CMD_BWD, 1'b1, 16'sd0, KNOWN,
          '{1'b0, 8'sd0, mssdf_pkg::RUN_BWD, 1'b0}},
        '{mssdf_pkg::CMD_STOP, 1'b0, 16'sd0, KNOWN,
          '{1'b0, 8'sd0, mssdf_pkg::RUN_STOP, 1'b0}},
        '{mssdf_pkg::CMD_FWD, 1'b0, 16'sd0, KNOWN,
          '{1'b0, 8'sd0, mssdf_pkg::RUN_FWD, 1'b0}},
        '{mssdf_pkg::CMD_BWD, 1'b0, 16'sd0, KNOWN,
          '{1'b0, 8'sd0, mssdf_pkg::RUN_FWD, 1'b1}},
        '{mssdf_pkg::CMD_TICK, 1'b0, 16'sd0, PREDICT, '0},
        '{mssdf_pkg::CMD_TICK, 1'b0, 16'sd0, PREDICT, '0},
        // direct drive ignores inhibit and leaves the run state alone
        '{mssdf_pkg::CMD_DIRECT, 1'b1, -16'sd5, KNOWN,
          '{1'b1, -8'sd5, mssdf_pkg::RUN_FWD, 1'b0}},
        '{mssdf_pkg::CMD_FWD, 1'b0, 16'sd0, KNOWN,
          '{1'b0, 8'sd0, mssdf_pkg::RUN_FWD, 1'b0}},
        // unused commands give an empty result
        '{CMD_UNUSED_FIRST, 1'b1, 16'sh7FFF, KNOWN,
          '{1'b0, 8'sd0, mssdf_pkg::RUN_FWD, 1'b0}},
        '{CMD_UNUSED_LAST, 1'b1, 16'shFFFF, KNOWN,
          '{1'b0, 8'sd0, mssdf_pkg::RUN_FWD, 1'b0}},
        '{mssdf_pkg::CMD_STOP, 1'b1, 16'sd0, KNOWN,
          '{1'b0, 8'sd0, mssdf_pkg::RUN_STOP, 1'b0}},
        '{mssdf_pkg::CMD_TICK, 1'b0, 16'sd0, KNOWN,
          '{1'b1, 8'sd0, mssdf_pkg::RUN_STOP, 1'b0}}
    };

    // Advance the shadow ramp speed by one tick: step toward the limit, truncate
    // toward zero, saturate to the speed range, then hold the floor of 30.
    function automatic void advance_ramp();
        longint target;
        longint divisor;
        longint num;
        longint mag;
        longint step;
        longint s;
        target = longint'(speed_limit) << FRAC_BITS;
        divisor = (ramp_time == 16'd0) ? 1 : longint'(ramp_time);
        num = longint'(tick_interval) * (target - longint'(ramp_speed));
        mag = (num < 0) ? -num : num;
        step = mag / divisor;
        if (num < 0)
            step = -step;
        s = longint'(ramp_speed) + step;
        if (s < 0)
            s = 0;
        if (s > SPEED_TOP)
            s = SPEED_TOP;
        if (s < SPEED_FLOOR)
            s = SPEED_FLOOR;
        ramp_speed = s[SPEED_W-1:0];
    endfunction

    // Work out the drive result of one request and update the shadow state.
    function automatic drive_result_t predict_drive(input logic [2:0] cmd, input logic inhibit,
                                                    input logic signed [15:0] direct_speed);
        drive_result_t r;
        r = '0;
        case (cmd)
            mssdf_pkg::CMD_TICK:
            begin
                advance_ramp();
                r.drive_write = 1'b1;
                if (motor_dir == mssdf_pkg::RUN_STOP || inhibit)
                    ramp_speed = '0;
                else
                begin
                    r.drive = 8'(ramp_speed >> FRAC_BITS);
                    if (motor_dir == mssdf_pkg::RUN_BWD)
                        r.drive = -r.drive;
                end
            end
            mssdf_pkg::CMD_FWD:
            begin
                if (motor_dir == mssdf_pkg::RUN_BWD)
                    r.rejected = 1'b1;
                else
                    motor_dir = mssdf_pkg::RUN_FWD;
            end
            mssdf_pkg::CMD_BWD:
            begin
                if (motor_dir == mssdf_pkg::RUN_FWD)
                    r.rejected = 1'b1;
                else
                    motor_dir = mssdf_pkg::RUN_BWD;
            end
            mssdf_pkg::CMD_STOP:
                motor_dir = mssdf_pkg::RUN_STOP;
            mssdf_pkg::CMD_DIRECT:
            begin
                r.drive_write = 1'b1;
                if (direct_speed < mssdf_pkg::DIRECT_MIN)
                    r.drive = mssdf_pkg::DRIVE_MIN;
                else if (direct_speed > mssdf_pkg::DIRECT_MAX)
                    r.drive = mssdf_pkg::DRIVE_MAX;
                else
                    r.drive = direct_speed[7:0];
            end
            default:
                ;
        endcase
        r.run_state = motor_dir;
        return r;
    endfunction

    // Offer one request, hold it until the block takes it, then record what it owes.
    // Idle cycles are inserted first; valid stays high between back-to-back requests.
    task automatic send_request(input logic [2:0] cmd, input logic inhibit,
                                input logic signed [15:0] direct_speed,
                                input bit known, input drive_result_t known_want);
        drive_result_t want;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
            request_if.valid <= 1'b0;
        end
        @(negedge clk);
        request_if.valid <= 1'b1;
        request_if.cmd <= cmd;
        request_if.inhibit <= inhibit;
        request_if.direct_speed <= direct_speed;
        do
            @(posedge clk);
        while (!request_if.ready);
        if (cmd == mssdf_pkg::CMD_TICK && !inhibit && motor_dir != mssdf_pkg::RUN_STOP)
            ramped_ticks++;
        want = predict_drive(cmd, inhibit, direct_speed);
        if (known)
            want = known_want;
        pending_results.push_back(want);
        requests_sent++;
    endtask

    // Drain the block, let it settle, then write all three registers back to back.
    task automatic apply_settings(input logic [15:0] limit_data, input logic [15:0] ramp,
                                  input logic [15:0] tick);
        @(negedge clk);
        request_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= mssdf_pkg::CFG_SPEED_LIMIT;
        cfg_data <= limit_data;
        speed_limit = limit_data[6:0];
        @(negedge clk);
        cfg_index <= mssdf_pkg::CFG_RAMP_TIME;
        cfg_data <= ramp;
        ramp_time = ramp;
        @(negedge clk);
        cfg_index <= mssdf_pkg::CFG_TICK_INTVL;
        cfg_data <= tick;
        tick_interval = tick;
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_applied++;
    endtask

    // Random requests, weighted so that the motor spends most of its time running
    // and ramping. Direction changes, stops and direct drives break in at random.
    // The first calm_items requests go with no idling on either side; the
    // request numbered hold_at asks the receiver for its long hold-off.
    task automatic run_random(input int count, input int calm_items, input int hold_at);
        int n;
        int pick;
        logic [2:0] cmd;
        logic inhibit;
        logic signed [15:0] direct_speed;
        for (n = 0; n < count; n++)
        begin
            calm = (n < calm_items);
            if (n == hold_at)
                hold_off_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 48)
                cmd = mssdf_pkg::CMD_TICK;
            else if (pick < 62)
                cmd = mssdf_pkg::CMD_FWD;
            else if (pick < 76)
                cmd = mssdf_pkg::CMD_BWD;
            else if (pick < 84)
                cmd = mssdf_pkg::CMD_STOP;
            else if (pick < 97)
                cmd = mssdf_pkg::CMD_DIRECT;
            else
                cmd = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
            inhibit = ($urandom_range(0, 99) < 12);
            if ($urandom_range(0, 1) == 0)
                direct_speed = 16'($urandom_range(16'hFFFF, 0));
            else
                direct_speed = 16'($signed($urandom_range(280, 0)) - 140);
            send_request(cmd, inhibit, direct_speed, PREDICT, '0);
        end
        calm = 1'b0;
    endtask

    // Free-running clock, 10 ns period.
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Abandon the run if it goes on far beyond any correct run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d results outstanding", $time,
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: ready drops about six percent of the time, never while calm.
    // On request, hold ready low for a long stretch so that the block backs up.
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
                hold_done = 1'b1;
            end
            else
                result_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check every accepted result against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_seen++;
            if (result_if.rejected)
                refusals_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got write %0b drive %0d",
                         $time, result_if.drive_write, result_if.drive);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (result_if.drive_write !== oldest.drive_write)
                begin
                    errors++;
                    $display("%0t: drive_write expected %0b, got %0b", $time,
                             oldest.drive_write, result_if.drive_write);
                end
                if (result_if.drive !== oldest.drive)
                begin
                    errors++;
                    $display("%0t: drive expected %0d, got %0d", $time,
                             oldest.drive, result_if.drive);
                end
                if (result_if.run_state !== oldest.run_state)
                begin
                    errors++;
                    $display("%0t: run_state expected %0d, got %0d", $time,
                             oldest.run_state, result_if.run_state);
                end
                if (result_if.rejected !== oldest.rejected)
                begin
                    errors++;
                    $display("%0t: rejected expected %0b, got %0b", $time,
                             oldest.rejected, result_if.rejected);
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases under different settings.
    initial
    begin
        rst_n = 1'b0;
        request_if.valid = 1'b0;
        request_if.cmd = mssdf_pkg::CMD_TICK;
        request_if.inhibit = 1'b0;
        request_if.direct_speed = '0;
        cfg_write = 1'b0;
        cfg_index = mssdf_pkg::CFG_SPEED_LIMIT;
        cfg_data = '0;
        calm = 1'b0;
        hold_off_req = 1'b0;
        hold_done = 1'b0;
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        ramped_ticks = 0;
        refusals_seen = 0;
        settings_applied = 0;
        cycle_count = 0;

        // Initialise the shadow state to the reset defaults.
        speed_limit = mssdf_pkg::SPEED_LIMIT_RST;
        ramp_time = mssdf_pkg::RAMP_TIME_RST;
        tick_interval = mssdf_pkg::TICK_INTVL_RST;
        motor_dir = mssdf_pkg::RUN_STOP;
        ramp_speed = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table under the reset settings, then random traffic.
        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].inhibit,
                         directed_rows[i].direct_speed, directed_rows[i].known,
                         directed_rows[i].want);
        run_random(120, 0, -1);

        // Top limit, shortest ramp, longest tick: the speed slams into saturation.
        apply_settings(16'h007F, 16'd1, 16'hFFFF);
        run_random(125, 0, -1);

        // Zero limit (upper data bits set), zero ramp time, zero tick interval:
        // the step vanishes and only the floor of 30 lifts the speed.
        apply_settings(16'hFF80, 16'd0, 16'd0);
        run_random(125, 100, -1);

        // Zero limit with a huge negative step: clamp to zero, then the floor.
        apply_settings(16'd0, 16'd1, 16'hFFFF);
        run_random(125, 0, -1);

        // Longest ramp with the shortest tick: the speed creeps, mostly on the floor.
        apply_settings(16'd127, 16'hFFFF, 16'd1);
        run_random(125, 0, 30);

        // Arbitrary settings across the full register range.
        apply_settings(16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(16'hFFFF, 0)),
                       16'($urandom_range(16'hFFFF, 0)));
        run_random(125, 0, -1);

        // Drop valid, wait for every owed result, then let the block settle.
        @(negedge clk);
        request_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d results over %0d register settings,",
                 requests_sent, results_seen, settings_applied + 1);
        $display("with %0d ramping ticks, %0d refused reversals, long hold-off %0s.",
                 ramped_ticks, refusals_seen, hold_done ? "done" : "missed");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
